// ----- design/drmq_pkg.sv -----
// ----------------------------------------------------------------------------
// drmq_pkg
// Shared constants, operation codes and helpers of the dual range-maximum
// query table.
// ----------------------------------------------------------------------------
package drmq_pkg;

  localparam int unsigned ValueBits      = 31;
  localparam int unsigned CountBits      = 11;
  localparam int unsigned IndexBits      = 10;
  localparam int unsigned OpBits         = 2;
  localparam int unsigned DefMaxElements = 1024;
  localparam int unsigned DefLevels      = 11;
  localparam int unsigned InDataBits     = 96;
  localparam int unsigned OutDataBits    = 64;

  localparam logic [CountBits-1:0] CountReset = 11'd1024;

  localparam logic [OpBits-1:0] OpLoad  = 2'd0;
  localparam logic [OpBits-1:0] OpBuild = 2'd1;
  localparam logic [OpBits-1:0] OpQuery = 2'd2;

  typedef logic [ValueBits-1:0] value_t;

  function automatic value_t vmax(input value_t x, input value_t y);
    vmax = (x > y) ? x : y;
  endfunction

endpackage

// ----- design/drmq_ram.sv -----
// ----------------------------------------------------------------------------
// drmq_ram
// Generic single-port RAM with one write or read per cycle and a registered
// read port.
// ----------------------------------------------------------------------------
module drmq_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dual_range_max_query_table_core.sv -----
// ----------------------------------------------------------------------------
// dual_range_max_query_table_core
// Sparse-table range-maximum engine over two parallel arrays.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the operation (load,
// build, query) and tdata the index, the two values and the query range.
// Every request gives exactly one result on the m_axis channel with both
// maxima and a status bit. The element count register is written on the
// cfg channel, which is always ready; write it only while the block is idle.
// The two level tables sit in single-port RAMs, and one max unit per array
// is shared by the build and the query. The block takes one request at a
// time and drops s_axis_tready until the result is in the output register,
// which happens in the cycle in which s_axis_tready returns. A load writes
// level 0, and a query reads two entries and takes their maxima; an invalid
// request or a build over fewer than two elements goes straight to the
// output. A build writes N - 2^j + 1 entries on each level j from 1 up while
// 2^j <= N and j < L, for N elements and L levels, and the one RAM port must
// do two reads and one write per entry. The result waits in the output
// register while the receiver stalls, and the next request is taken
// meanwhile.
// Reset empties the output, returns to idle and sets the count to 1024.
// The tables are not cleared; build before querying upper levels.
// ----------------------------------------------------------------------------
module dual_range_max_query_table_core
  import drmq_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = DefMaxElements,
  parameter int unsigned LEVELS       = DefLevels
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Lowest bit up: element_index, value_a, value_b, range_low, range_high.
  input  logic [InDataBits-1:0]  s_axis_tdata,
  // Lowest bit up: operation.
  input  logic [OpBits-1:0]      s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Lowest bit up: max_first, max_second, status.
  output logic [OutDataBits-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [CountBits-1:0]   cfg_data_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o
);

  localparam int unsigned IW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned AW    = LW + IW;
  localparam int unsigned DEPTH = LEVELS * (2 ** IW);
  localparam int unsigned NW0   = (IW + 1 > CountBits) ? IW + 1 : CountBits;
  localparam int unsigned NW    = (NW0 > LEVELS + 1) ? NW0 : LEVELS + 1;
  localparam int unsigned KW    = $clog2(NW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_BRD0 = 4'd2;
  localparam logic [3:0] S_BRD1 = 4'd3;
  localparam logic [3:0] S_BWR  = 4'd4;
  localparam logic [3:0] S_QRD0 = 4'd5;
  localparam logic [3:0] S_QRD1 = 4'd6;
  localparam logic [3:0] S_QCMP = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [LW-1:0]        lvl_q, lvl_d;
  logic [IW-1:0]        pos_q, pos_d;
  logic [IW-1:0]        pos2_q, pos2_d;
  value_t               va_q, va_d, vb_q, vb_d;
  value_t               hold_a_q, hold_a_d, hold_b_q, hold_b_d;
  value_t               res_a_q, res_a_d, res_b_q, res_b_d;
  logic                 res_st_q, res_st_d;
  logic                 out_valid_q, out_valid_d;
  value_t               out_a_q, out_a_d, out_b_q, out_b_d;
  logic                 out_st_q, out_st_d;

  logic [IndexBits-1:0] in_idx, in_lo, in_hi;
  value_t               in_va, in_vb;
  logic [NW-1:0]        cnt_w, len_w, start2_w, span_w, next_i_w;
  logic [KW-1:0]        k_raw, k_w;
  logic                 accept;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  value_t               ram_wa, ram_wb, rd_a, rd_b;
  value_t               max_a, max_b;

  assign in_idx = s_axis_tdata[9:0];
  assign in_va  = s_axis_tdata[40:10];
  assign in_vb  = s_axis_tdata[71:41];
  assign in_lo  = s_axis_tdata[81:72];
  assign in_hi  = s_axis_tdata[91:82];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign cnt_w = (NW'(count_q) > NW'(MAX_ELEMENTS)) ? NW'(MAX_ELEMENTS) : NW'(count_q);

  // Window level of a query: floor of log2 of the range length, clamped.
  assign len_w = NW'(in_hi) - NW'(in_lo) + NW'(1);
  always_comb begin
    k_raw = '0;
    for (int b = 0; b < NW; b++) begin
      if (len_w[b]) begin
        k_raw = KW'(b);
      end
    end
  end
  assign k_w      = (k_raw > KW'(LEVELS - 1)) ? KW'(LEVELS - 1) : k_raw;
  assign start2_w = NW'(in_hi) + NW'(1) - (NW'(1) << k_w);

  assign span_w   = NW'(1) << lvl_q;
  assign next_i_w = NW'(pos_q) + NW'(1);

  // Shared max unit, one lane per array.
  assign max_a = vmax(hold_a_q, rd_a);
  assign max_b = vmax(hold_b_q, rd_b);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = {lvl_q, pos_q};
    ram_wa   = max_a;
    ram_wb   = max_b;
    unique case (state_q)
      S_LOAD: begin
        ram_we   = 1'b1;
        ram_addr = {LW'(0), pos_q};
        ram_wa   = va_q;
        ram_wb   = vb_q;
      end
      S_BRD0: ram_addr = {lvl_q - LW'(1), pos_q};
      S_BRD1: ram_addr = {lvl_q - LW'(1), pos_q + IW'(span_w >> 1)};
      S_BWR: begin
        ram_we = 1'b1;
      end
      S_QRD1: ram_addr = {lvl_q, pos2_q};
      default: ram_addr = {lvl_q, pos_q};
    endcase
  end

  drmq_ram #(.WIDTH(ValueBits), .DEPTH(DEPTH)) u_ram_first (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wa),
    .rdata_o (rd_a)
  );

  drmq_ram #(.WIDTH(ValueBits), .DEPTH(DEPTH)) u_ram_second (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wb),
    .rdata_o (rd_b)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lvl_d       = lvl_q;
    pos_d       = pos_q;
    pos2_d      = pos2_q;
    va_d        = va_q;
    vb_d        = vb_q;
    hold_a_d    = hold_a_q;
    hold_b_d    = hold_b_q;
    res_a_d     = res_a_q;
    res_b_d     = res_b_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    out_st_d    = out_st_q;

    if (cfg_valid_i) begin
      count_d = cfg_data_i;
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_a_d  = '0;
          res_b_d  = '0;
          res_st_d = 1'b0;
          va_d     = in_va;
          vb_d     = in_vb;
          case (s_axis_tuser)
            OpLoad: begin
              pos_d = IW'(NW'(in_idx));
              if (NW'(in_idx) < NW'(MAX_ELEMENTS)) begin
                state_d = S_LOAD;
              end else begin
                res_st_d = 1'b1;
                state_d  = S_OUT;
              end
            end
            OpBuild: begin
              lvl_d = LW'(1);
              pos_d = '0;
              if (cnt_w < NW'(2)) begin
                state_d = S_OUT;
              end else begin
                state_d = S_BRD0;
              end
            end
            OpQuery: begin
              if (in_lo > in_hi || NW'(in_hi) >= cnt_w) begin
                res_st_d = 1'b1;
                state_d  = S_OUT;
              end else begin
                lvl_d   = LW'(k_w);
                pos_d   = IW'(NW'(in_lo));
                pos2_d  = IW'(start2_w);
                state_d = S_QRD0;
              end
            end
            default: begin
              res_st_d = 1'b1;
              state_d  = S_OUT;
            end
          endcase
        end
      end
      S_LOAD: state_d = S_OUT;
      S_BRD0: state_d = S_BRD1;
      S_BRD1: begin
        hold_a_d = rd_a;
        hold_b_d = rd_b;
        state_d  = S_BWR;
      end
      S_BWR: begin
        if (next_i_w + span_w <= cnt_w) begin
          pos_d   = IW'(next_i_w);
          state_d = S_BRD0;
        end else if ((NW'(lvl_q) + NW'(1) < NW'(LEVELS)) && ((span_w << 1) <= cnt_w)) begin
          lvl_d   = lvl_q + LW'(1);
          pos_d   = '0;
          state_d = S_BRD0;
        end else begin
          state_d = S_OUT;
        end
      end
      S_QRD0: state_d = S_QRD1;
      S_QRD1: begin
        hold_a_d = rd_a;
        hold_b_d = rd_b;
        state_d  = S_QCMP;
      end
      S_QCMP: begin
        res_a_d = max_a;
        res_b_d = max_b;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_a_d     = res_a_q;
          out_b_d     = res_b_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CountReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    pos_q    <= pos_d;
    pos2_q   <= pos2_d;
    va_q     <= va_d;
    vb_q     <= vb_d;
    hold_a_q <= hold_a_d;
    hold_b_q <= hold_b_d;
    res_a_q  <= res_a_d;
    res_b_q  <= res_b_d;
    res_st_q <= res_st_d;
    out_a_q  <= out_a_d;
    out_b_q  <= out_b_d;
    out_st_q <= out_st_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_st_q, out_b_q, out_a_q};

endmodule

// ----- design/drmq_checker.sv -----
// ----------------------------------------------------------------------------
// drmq_checker
// Port-level checks of the dual range-maximum query table, bound to the top.
// ----------------------------------------------------------------------------
module drmq_checker
  import drmq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [OutDataBits-1:0] m_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  // The block is busy in the cycle after it accepts a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again in the cycle after a request");

  // A new result only appears when the block was busy in the cycle before.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work in progress");

  // An error result carries zero maxima.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[62] |-> m_axis_tdata[61:0] == '0)
    else $error("error result with nonzero maxima");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind dual_range_max_query_table_core drmq_checker u_drmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ----- dv/tb_dual_range_max_query_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_range_max_query_table_core
// Self-checking bench for the dual range-maximum query table. A short table
// of directed requests covers the value and index extremes, every operation,
// the unused opcode, reversed and out-of-count ranges, and counts of zero,
// one and four. Random phases follow, each under a new element count, some
// of them above the table size. Typed rows expect zero maxima and their
// status; a behavioral copy of the sparse table predicts all others. Builds
// only run over loaded elements, and queries only aim at entries that a load
// or a build has defined. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_dual_range_max_query_table_core;
  import drmq_pkg::*;

  localparam logic [OpBits-1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned NumRows = 26;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned OpsPerPhase = 30;
  localparam int unsigned LoadLimit = 160;
  localparam value_t VMax = '1;
  localparam value_t VAlt = 31'h2AAAAAAA;
  localparam value_t VInv = 31'h55555555;

  typedef struct packed {
    logic [OpBits-1:0]    op;
    logic [IndexBits-1:0] idx;
    value_t               va;
    value_t               vb;
    logic [IndexBits-1:0] lo;
    logic [IndexBits-1:0] hi;
  } request_t;

  typedef struct packed {
    value_t max_first;
    value_t max_second;
    logic   status;
  } maxima_t;

  typedef enum logic {RowRequest, RowCount} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    request_t             req;
    logic [CountBits-1:0] count;
    logic                 typed;
    logic                 exp_status;
  } row_t;

  localparam row_t DirectedRows [NumRows] = '{
    '{RowRequest, '{OpUnused, 10'h3FF, VMax, VMax, 10'h3FF, 10'h3FF}, 11'd0, 1'b1, 1'b1},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd5, 10'd4}, 11'd0, 1'b1, 1'b1},
    '{RowRequest, '{OpLoad, 10'd0, VMax, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpLoad, 10'h3FF, 31'd0, VMax, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b0, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'h3FF, 10'h3FF}, 11'd0, 1'b0, 1'b0},
    '{RowCount, '{OpLoad, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b0, 1'b0},
    '{RowRequest, '{OpBuild, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b1},
    '{RowCount, '{OpLoad, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd4, 1'b0, 1'b0},
    '{RowRequest, '{OpLoad, 10'd1, VAlt, VInv, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpLoad, 10'd2, VInv, VAlt, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpLoad, 10'd3, 31'd7, 31'd7, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpBuild, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd0, 10'd3}, 11'd0, 1'b0, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd1, 10'd2}, 11'd0, 1'b0, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd3, 10'd3}, 11'd0, 1'b0, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd0, 10'd4}, 11'd0, 1'b1, 1'b1},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd3, 10'd0}, 11'd0, 1'b1, 1'b1},
    '{RowCount, '{OpLoad, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd1, 1'b0, 1'b0},
    '{RowRequest, '{OpBuild, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b0, 1'b0},
    '{RowRequest, '{OpQuery, 10'd0, 31'd0, 31'd0, 10'd0, 10'd1}, 11'd0, 1'b1, 1'b1},
    '{RowRequest, '{OpLoad, 10'h2AA, VInv, VAlt, 10'h155, 10'h2AA}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpLoad, 10'h155, VAlt, VInv, 10'h2AA, 10'h155}, 11'd0, 1'b1, 1'b0},
    '{RowRequest, '{OpUnused, 10'd0, 31'd0, 31'd0, 10'd0, 10'd0}, 11'd0, 1'b1, 1'b1}
  };

  localparam int unsigned PhaseCounts [NumPhases] = '{
    2, 1, 37, 0, 64, 5, 129, 16, 1024, 2047, 3, 1000
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic [OpBits-1:0]      s_axis_tuser;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [CountBits-1:0]   cfg_data_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;

  value_t               level_first [DefLevels][DefMaxElements];
  value_t               level_second [DefLevels][DefMaxElements];
  bit                   level_known [DefLevels][DefMaxElements];
  logic [CountBits-1:0] count_q;
  maxima_t              pending_maxima [$];
  int unsigned          mismatches;
  int unsigned          cycles;
  int unsigned          send_idle;
  int unsigned          recv_idle;

  dual_range_max_query_table_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned window_level(input int unsigned len);
    int unsigned k;
    k = 0;
    while (len > 1) begin
      len = len >> 1;
      k++;
    end
    if (k > DefLevels - 1) begin
      k = DefLevels - 1;
    end
    return k;
  endfunction

  function automatic int unsigned active_count();
    return (count_q > DefMaxElements) ? DefMaxElements : count_q;
  endfunction

  function automatic value_t random_value();
    case ($urandom_range(3))
      0: return value_t'($urandom_range(15));
      1: return VMax - value_t'($urandom_range(15));
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic maxima_t predict_maxima(input request_t r);
    maxima_t     res;
    int unsigned cnt, span, half, k, second, i, j;
    res = '0;
    cnt = active_count();
    case (r.op)
      OpLoad: begin
        level_first[0][r.idx] = r.va;
        level_second[0][r.idx] = r.vb;
        level_known[0][r.idx] = 1'b1;
      end
      OpBuild: begin
        for (j = 1; j < DefLevels && (1 << j) <= cnt; j++) begin
          span = 1 << j;
          half = span >> 1;
          for (i = 0; i + span <= cnt; i++) begin
            level_first[j][i] = (level_first[j-1][i] > level_first[j-1][i+half]) ?
                                level_first[j-1][i] : level_first[j-1][i+half];
            level_second[j][i] = (level_second[j-1][i] > level_second[j-1][i+half]) ?
                                 level_second[j-1][i] : level_second[j-1][i+half];
            level_known[j][i] = level_known[j-1][i] && level_known[j-1][i+half];
          end
        end
      end
      OpQuery: begin
        if (r.lo > r.hi || r.hi >= cnt) begin
          res.status = 1'b1;
        end else begin
          k = window_level(r.hi - r.lo + 1);
          second = r.hi + 1 - (1 << k);
          res.max_first = (level_first[k][r.lo] > level_first[k][second]) ?
                          level_first[k][r.lo] : level_first[k][second];
          res.max_second = (level_second[k][r.lo] > level_second[k][second]) ?
                           level_second[k][r.lo] : level_second[k][second];
        end
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    return res;
  endfunction

  task automatic send_request(input request_t r, input logic typed, input logic exp_status);
    maxima_t m;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.op;
    s_axis_tdata <= {4'b0, r.hi, r.lo, r.vb, r.va, r.idx};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    m = predict_maxima(r);
    if (typed) begin
      m = '0;
      m.status = exp_status;
    end
    pending_maxima.push_back(m);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_maxima.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CountBits-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    count_q = value;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    maxima_t got;
    maxima_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.max_first = m_axis_tdata[ValueBits-1:0];
      got.max_second = m_axis_tdata[2*ValueBits-1:ValueBits];
      got.status = m_axis_tdata[2*ValueBits];
      if (pending_maxima.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request waiting, actual %h %h %b", $time,
                 got.max_first, got.max_second, got.status);
      end else begin
        want = pending_maxima.pop_front();
        if (got.max_first !== want.max_first || got.max_second !== want.max_second ||
            got.status !== want.status) begin
          mismatches++;
          $display("%0t: expected %h %h %b, actual %h %h %b", $time,
                   want.max_first, want.max_second, want.status,
                   got.max_first, got.max_second, got.status);
        end
      end
    end
  end

  initial begin
    request_t    r;
    row_t        row;
    int unsigned ph, n, i, cnt, tries, k, pick, lo_v, hi_v;
    logic        found;
    logic        full;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    count_q = CountReset;
    mismatches = 0;
    send_idle = 29;
    recv_idle = 53;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < NumRows; n++) begin
      row = DirectedRows[n];
      if (row.kind == RowCount) begin
        write_count(row.count);
      end else begin
        send_request(row.req, row.typed, row.exp_status);
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      send_idle = (ph < 4) ? 29 : (ph < 8) ? 53 : 0;
      recv_idle = (ph < 4) ? 53 : (ph < 8) ? 29 : 0;
      write_count(CountBits'(PhaseCounts[ph]));
      cnt = active_count();
      // Small counts get every element loaded; a build runs only when all
      // elements under the count hold loaded values.
      if (cnt <= LoadLimit) begin
        for (i = 0; i < cnt; i++) begin
          if (!level_known[0][i]) begin
            r = '0;
            r.op = OpLoad;
            r.idx = IndexBits'(i);
            r.va = random_value();
            r.vb = random_value();
            send_request(r, 1'b0, 1'b0);
          end
        end
      end
      full = 1'b1;
      for (i = 0; i < cnt; i++) begin
        if (!level_known[0][i]) begin
          full = 1'b0;
        end
      end
      r = '0;
      if (full) begin
        r.op = OpBuild;
        send_request(r, 1'b0, 1'b0);
      end

      for (n = 0; n < OpsPerPhase; n++) begin
        r.idx = IndexBits'($urandom_range(1023, 0));
        r.va = random_value();
        r.vb = random_value();
        r.lo = IndexBits'($urandom_range(1023, 0));
        r.hi = IndexBits'($urandom_range(1023, 0));
        pick = $urandom_range(99);
        if (pick < 12) begin
          r.op = OpLoad;
        end else if (pick < 16) begin
          r.op = full ? OpBuild : OpLoad;
        end else if (pick < 94) begin
          r.op = OpQuery;
          found = 1'b0;
          lo_v = 0;
          hi_v = 0;
          if (pick < 80) begin
            for (tries = 0; tries < 8 && !found && cnt != 0; tries++) begin
              lo_v = $urandom_range(cnt - 1, 0);
              if ($urandom_range(1) != 0) begin
                hi_v = lo_v + $urandom_range((cnt - 1 - lo_v < 3) ? cnt - 1 - lo_v : 3, 0);
              end else begin
                hi_v = $urandom_range(cnt - 1, lo_v);
              end
              k = window_level(hi_v - lo_v + 1);
              found = level_known[k][lo_v] && level_known[k][hi_v + 1 - (1 << k)];
            end
          end
          if (!found) begin
            if (cnt < DefMaxElements && $urandom_range(1) != 0) begin
              hi_v = $urandom_range(1023, cnt);
              lo_v = $urandom_range(hi_v, 0);
            end else begin
              hi_v = $urandom_range(1022, 0);
              lo_v = $urandom_range(1023, hi_v + 1);
            end
          end
          r.lo = IndexBits'(lo_v);
          r.hi = IndexBits'(hi_v);
        end else begin
          r.op = OpUnused;
        end
        send_request(r, 1'b0, 1'b0);
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending_maxima.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
